// File: hw/rtl/kptf_pkg.sv
// Package for the keyed property table: word types, defaults, controller codes.
package kptf_pkg;

	// Default sizes of the table
	localparam int ENTRIES_DEF    = 16;
	localparam int KEY_WIDTH_DEF  = 32;
	localparam int PROPS_DEF      = 4;
	localparam int PROP_WIDTH_DEF = 32;

	// Operation codes
	localparam logic OP_FIND = 1'b0;
	localparam logic OP_SET  = 1'b1;

	// Request word
	typedef struct packed {
		logic        op;
		logic [31:0] key;
		logic [1:0]  prop_index;
		logic [31:0] write_value;
	} in_t;

	// Response word
	typedef struct packed {
		logic        found;
		logic [31:0] read_value;
		logic [3:0]  slot;
	} out_t;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_SEL,
		ST_WB
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;
		logic compare;
		logic select;
		logic commit;
	} cmd_t;

endpackage

// File: hw/rtl/kptf_ctrl.sv
// Controller of the keyed property table: sequences one word through compare, select, write-back.
module kptf_ctrl
	import kptf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;

	// State and output-valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CMP;
				end
			end
			ST_CMP: begin
				cmd.compare = 1'b1;
				state_d     = ST_SEL;
			end
			ST_SEL: begin
				cmd.select = 1'b1;
				state_d    = ST_WB;
			end
			ST_WB: begin
				// hold until the output register is free
				if (!out_valid_q || out_ready) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// File: hw/rtl/kptf_dp.sv
// Datapath of the keyed property table: key registers, match vector, property row memory.
module kptf_dp
	import kptf_pkg::*;
#(
	parameter int ENTRIES    = ENTRIES_DEF,
	parameter int KEY_WIDTH  = KEY_WIDTH_DEF,
	parameter int PROPS      = PROPS_DEF,
	parameter int PROP_WIDTH = PROP_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t cmd,
	input  in_t  in_data,
	output out_t out_data
);

	localparam int SW = $clog2(ENTRIES);

	typedef logic [PROPS-1:0][PROP_WIDTH-1:0] row_t;

	in_t                  item_q;
	logic [KEY_WIDTH-1:0] keys_q [ENTRIES];
	logic [ENTRIES-1:0]   valid_q;
	logic [ENTRIES-1:0]   match_q;
	logic [SW-1:0]        ws_q;
	logic                 hit_q;
	logic [SW-1:0]        slot_q;
	row_t                 row_mem [ENTRIES];
	row_t                 row_rd_q;
	out_t                 out_q;

	logic [63:0]           key_ext;
	logic [KEY_WIDTH-1:0]  key_n;
	logic [63:0]           wv_ext;
	logic [PROP_WIDTH-1:0] wv_n;
	logic                  hit;
	logic [SW-1:0]         hit_enc;
	logic [SW-1:0]         tgt;
	logic                  claim;
	row_t                  row_new;
	logic [PROP_WIDTH-1:0] word_sel;
	logic [63:0]           word_ext;
	logic [15:0]           slot_ext;
	out_t                  out_n;

	// Fit the request fields to the table widths
	assign key_ext = 64'(item_q.key);
	assign key_n   = key_ext[KEY_WIDTH-1:0];
	assign wv_ext  = 64'(item_q.write_value);
	assign wv_n    = wv_ext[PROP_WIDTH-1:0];

	// Pick the highest matching slot
	always_comb begin
		hit_enc = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (match_q[i]) begin
				hit_enc = SW'(i);
			end
		end
	end

	assign hit   = |match_q;
	assign tgt   = hit ? hit_enc : ws_q;
	assign claim = (item_q.op == OP_SET) && !hit;

	// Latch the request word
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= in_data;
		end
	end

	// Compare the key against every slot at once
	always_ff @(posedge clk) begin
		if (cmd.compare) begin
			for (int i = 0; i < ENTRIES; i++) begin
				match_q[i] <= valid_q[i] && (keys_q[i] == key_n);
			end
		end
	end

	// Hold the selection result for write-back
	always_ff @(posedge clk) begin
		if (cmd.select) begin
			hit_q  <= hit;
			slot_q <= tgt;
		end
	end

	// Claim a slot on a set miss: key, valid bit and ring pointer
	always_ff @(posedge clk) begin
		if (cmd.select && claim) begin
			keys_q[ws_q] <= key_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			ws_q    <= '0;
		end else if (cmd.select && claim) begin
			valid_q[ws_q] <= 1'b1;
			ws_q          <= (ws_q == SW'(ENTRIES - 1)) ? '0 : ws_q + SW'(1);
		end
	end

	// Property row memory: registered read at select, write at commit
	always_ff @(posedge clk) begin
		if (cmd.select) begin
			row_rd_q <= row_mem[tgt];
		end
		if (cmd.commit && (item_q.op == OP_SET)) begin
			row_mem[slot_q] <= row_new;
		end
	end

	// Build the new row and pick the addressed word
	always_comb begin
		row_new  = hit_q ? row_rd_q : '0;
		word_sel = '0;
		for (int p = 0; p < PROPS; p++) begin
			if (int'(item_q.prop_index) == p) begin
				row_new[p] = wv_n;
				word_sel   = row_rd_q[p];
			end
		end
	end

	// Form the response word
	always_comb begin
		word_ext         = 64'(word_sel);
		slot_ext         = 16'(slot_q);
		out_n.found      = hit_q;
		out_n.read_value = ((item_q.op == OP_FIND) && hit_q) ? word_ext[31:0] : '0;
		out_n.slot       = ((item_q.op == OP_SET) || hit_q) ? slot_ext[3:0] : '0;
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_q <= out_n;
		end
	end

	assign out_data = out_q;

endmodule

// File: hw/rtl/keyed_property_table_fifo.sv
// Top level of the keyed property table with first-in first-out replacement.
//
//   channel   signals                              word
//   request   in_valid / in_ready / in_data        in_t: op, key, prop_index, write_value
//   response  out_valid / out_ready / out_data     out_t: found, read_value, slot
//
// Each request word passes through accept, parallel key compare over all slots,
// priority select with the registered row-memory read, then write-back into the
// output register. One word is in flight at a time; the next one is accepted in the
// cycle after write-back, even while the response still waits in the output register.
// Write-back stalls while a previous response has not been taken.
// Reset clears the valid bits, the ring pointer and the controller at once; no sweep.
module keyed_property_table_fifo
	import kptf_pkg::*;
#(
	parameter int ENTRIES    = ENTRIES_DEF,
	parameter int KEY_WIDTH  = KEY_WIDTH_DEF,
	parameter int PROPS      = PROPS_DEF,
	parameter int PROP_WIDTH = PROP_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	cmd_t cmd;

	// Sequence control
	kptf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// Table storage and lookup
	kptf_dp #(
		.ENTRIES    (ENTRIES),
		.KEY_WIDTH  (KEY_WIDTH),
		.PROPS      (PROPS),
		.PROP_WIDTH (PROP_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_data  (in_data),
		.out_data (out_data)
	);

`ifndef SYNTHESIS
	// Never overwrite a response that has not been taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid || out_ready))
		else $error("response overwritten before it was taken");

	// Load the request register only on an accepted word
	a_load_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (in_valid && in_ready))
		else $error("request loaded without handshake");

	// Accept one word and finish it before taking another
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (!in_ready ##1 !in_ready ##1 !in_ready))
		else $error("request accepted while one is in flight");

	// Commit once per word
	a_single_commit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> !cmd.commit)
		else $error("double commit");
`endif

endmodule

// File: bench/tb.sv
// Testbench for the keyed property table: random and directed find/set words vs a predictor.
module tb;
	import kptf_pkg::*;

	localparam int KEY_POOL   = 24;
	localparam int RAND_WORDS = 400;
	localparam int STALL_MAX  = 2000;
	localparam int DRAIN_WAIT = 12;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic in_valid  = 1'b0;
	logic in_ready;
	in_t  in_data   = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;

	// Pending request words and the replies they are predicted to give
	in_t  pending_words[$];
	out_t expected_replies[$];

	// Predicted table contents
	bit [31:0] slot_key[ENTRIES_DEF];
	bit        slot_live[ENTRIES_DEF];
	bit [31:0] slot_prop[ENTRIES_DEF][PROPS_DEF];
	int        claim_ptr = 0;

	int words_sent     = 0;
	int replies_seen   = 0;
	int mismatch_count = 0;
	int stall_cycles   = 0;

	keyed_property_table_fifo uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic in_t make_word(logic op, logic [31:0] key, logic [1:0] pidx,
			logic [31:0] value);
		in_t w;
		w.op          = op;
		w.key         = key;
		w.prop_index  = pidx;
		w.write_value = value;
		return w;
	endfunction

	// Look the key up in the predicted table, apply a set, and return the reply
	function automatic out_t predict_reply(in_t w);
		out_t r;
		int   hit;
		int   claim;
		r   = '0;
		hit = -1;
		for (int i = ENTRIES_DEF - 1; i >= 0; i--) begin
			if (hit < 0 && slot_live[i] && slot_key[i] == w.key)
				hit = i;
		end
		if (w.op == OP_FIND) begin
			if (hit >= 0) begin
				r.found      = 1'b1;
				r.slot       = 4'(hit);
				r.read_value = slot_prop[hit][w.prop_index];
			end
		end else begin
			if (hit >= 0) begin
				r.found = 1'b1;
				claim   = hit;
			end else begin
				// Evict the oldest entry and clear its properties
				claim     = claim_ptr;
				claim_ptr = (claim_ptr == ENTRIES_DEF - 1) ? 0 : claim_ptr + 1;
				slot_key[claim]  = w.key;
				slot_live[claim] = 1'b1;
				for (int p = 0; p < PROPS_DEF; p++)
					slot_prop[claim][p] = '0;
			end
			r.slot = 4'(claim);
			slot_prop[claim][w.prop_index] = w.write_value;
		end
		return r;
	endfunction

	// Drive request words; hold each one until it is taken
	always @(posedge clk) begin
		if (arst_n && (!in_valid || in_ready)) begin
			if (pending_words.size() > 0 &&
					((words_sent >= 150 && words_sent < 250) || $urandom_range(99) >= 24)) begin
				in_valid   <= 1'b1;
				in_data    <= pending_words.pop_front();
				words_sent <= words_sent + 1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Stall the response side at random, except for a quiet stretch
	always @(posedge clk) begin
		if (arst_n)
			out_ready <= (replies_seen >= 150 && replies_seen < 250) || $urandom_range(99) >= 24;
	end

	// Predict on each accepted request; check each accepted reply
	always @(posedge clk) begin
		out_t want;
		if (arst_n) begin
			if (in_valid && in_ready)
				expected_replies.push_back(predict_reply(in_data));
			if (out_valid && out_ready) begin
				replies_seen <= replies_seen + 1;
				if (expected_replies.size() == 0) begin
					$error("unexpected reply: found %0d read_value %h slot %0d",
						out_data.found, out_data.read_value, out_data.slot);
					mismatch_count++;
				end else begin
					want = expected_replies.pop_front();
					if (out_data.found !== want.found) begin
						$error("found: expected %0d, got %0d", want.found, out_data.found);
						mismatch_count++;
					end
					if (out_data.read_value !== want.read_value) begin
						$error("read_value: expected %h, got %h", want.read_value,
							out_data.read_value);
						mismatch_count++;
					end
					if (out_data.slot !== want.slot) begin
						$error("slot: expected %0d, got %0d", want.slot, out_data.slot);
						mismatch_count++;
					end
				end
			end
		end
	end

	// Watchdog: end the run if nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_MAX) begin
				$display("tb: FAIL");
				$finish;
			end
		end
	end

	initial begin
		logic [31:0] key_pool[KEY_POOL];
		in_t         w;
		int          roll;

		// Directed: empty table, extremes, overwrite, fill and wrap-around eviction
		pending_words.push_back(make_word(OP_FIND, 32'h0, 2'd0, 32'h0));
		pending_words.push_back(make_word(OP_SET, 32'h0, 2'd0, 32'hFFFF_FFFF));
		pending_words.push_back(make_word(OP_FIND, 32'h0, 2'd0, 32'hFFFF_FFFF));
		pending_words.push_back(make_word(OP_FIND, 32'h0, 2'd3, 32'h0));
		pending_words.push_back(make_word(OP_SET, 32'hFFFF_FFFF, 2'd3, 32'hFFFF_FFFF));
		pending_words.push_back(make_word(OP_FIND, 32'hFFFF_FFFF, 2'd3, 32'h0));
		pending_words.push_back(make_word(OP_SET, 32'hFFFF_FFFF, 2'd3, 32'h0));
		pending_words.push_back(make_word(OP_FIND, 32'hFFFF_FFFF, 2'd3, 32'hFFFF_FFFF));
		for (int i = 2; i < ENTRIES_DEF; i++)
			pending_words.push_back(make_word(OP_SET, 32'hA5A5_0000 | i, 2'(i), i));
		pending_words.push_back(make_word(OP_SET, 32'h5A5A_5A5A, 2'd1, 32'h1234_5678));
		pending_words.push_back(make_word(OP_FIND, 32'h0, 2'd0, 32'h0));
		pending_words.push_back(make_word(OP_FIND, 32'h5A5A_5A5A, 2'd0, 32'h0));

		// Random: mostly keys from a pool a little larger than the table, some stray keys
		key_pool[0] = 32'h0;
		key_pool[1] = 32'hFFFF_FFFF;
		for (int i = 2; i < KEY_POOL; i++)
			key_pool[i] = $urandom();
		for (int n = 0; n < RAND_WORDS; n++) begin
			w.op         = 1'($urandom_range(1));
			w.prop_index = 2'($urandom_range(3));
			roll = $urandom_range(99);
			w.key = (roll < 85) ? key_pool[$urandom_range(KEY_POOL - 1)] : $urandom();
			roll = $urandom_range(99);
			if (roll < 10)
				w.write_value = 32'hFFFF_FFFF;
			else if (roll < 20)
				w.write_value = 32'h0;
			else
				w.write_value = $urandom();
			pending_words.push_back(w);
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for every word to be taken and every reply to arrive, then a short drain
		@(negedge clk);
		while (pending_words.size() != 0 || in_valid || expected_replies.size() != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
		if (mismatch_count == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
